### rtl/core/aroon_pkg.sv
// Shared types and constants for the Aroon window extremum block.
// Used by aroon_cell, aroon_div and aroon_window_extremum_age_top; no dependencies.
`default_nettype none

package aroon_pkg;

   localparam int MAX_PERIOD = 63;
   localparam int WIN_DEPTH  = MAX_PERIOD + 1;
   localparam int PERIOD_W   = 6;
   localparam int AGE_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int SAMPLE_W   = 32;
   localparam int RESULT_W   = 15;
   localparam int NUMER_W    = 21;
   localparam int STEP_W     = 5;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd25;
   localparam logic [COUNT_W-1:0]  COUNT_FULL   = 7'(WIN_DEPTH);
   localparam logic [AGE_W-1:0]    SCAN_LAST    = 6'(WIN_DEPTH - 1);
   localparam logic [NUMER_W-1:0]  FULL_SCALE   = 21'd25600;
   localparam logic [STEP_W-1:0]   STEP_LAST    = 5'(NUMER_W - 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] high_sample;
      logic signed [SAMPLE_W-1:0] low_sample;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] aroon_up;
      logic [RESULT_W-1:0] aroon_down;
   } rsp_type;

   // Running extremum handed from cell to cell during a scan.
   typedef struct packed {
      logic                       seen;
      logic signed [SAMPLE_W-1:0] max_key;
      logic [AGE_W-1:0]           max_age;
      logic signed [SAMPLE_W-1:0] min_key;
      logic [AGE_W-1:0]           min_age;
   } best_type;

endpackage

`default_nettype wire

### rtl/core/aroon_window_extremum_age_top.sv
// Aroon up/down over a sliding window of high and low prices: a row of
// aroon_cell instances and two aroon_div instances. Uses aroon_pkg.
//
// Each accepted word shifts one high/low pair into a row of 64 cells, the
// newest in the first cell. While fewer than period+1 words are held the word
// gives no result and the next word is taken in the following cycle. Otherwise
// the running maximum and minimum travel down the whole row, one cell per
// cycle, and two serial dividers then scale the ages, one bit per cycle.
// The next word is taken only once the result is in the result register,
// which lets the next word in while a result still waits on rsp_stall.
// The period register may only be written while the block is idle.
`default_nettype none

module aroon_window_extremum_age_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  aroon_pkg::req_type         req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output aroon_pkg::rsp_type               rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [aroon_pkg::PERIOD_W-1:0]   csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [aroon_pkg::AGE_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic [aroon_pkg::COUNT_W-1:0]    warm_ff, warm_in;
   logic [aroon_pkg::PERIOD_W-1:0]   period_ff, period_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   aroon_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [aroon_pkg::PERIOD_W-1:0]   eff_period;
   logic                             req_accept;
   logic                             warm_ok;
   logic                             div_start;
   logic                             rsp_load;
   logic                             up_done, down_done;
   logic [aroon_pkg::RESULT_W-1:0]   up_quot, down_quot;
   logic [aroon_pkg::NUMER_W-1:0]    up_numer, down_numer;

   aroon_pkg::req_type  sample_q [0:aroon_pkg::WIN_DEPTH-1];
   aroon_pkg::best_type best_q   [0:aroon_pkg::WIN_DEPTH-1];
   aroon_pkg::best_type best_none;

   assign eff_period = (period_ff == '0) ? 6'd1 : period_ff;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign best_none  = '0;

   always_comb begin
      warm_in = warm_ff;
      if (req_accept && (warm_ff != aroon_pkg::COUNT_FULL)) begin
         warm_in = warm_ff + 1'b1;
      end
   end

   assign warm_ok = (warm_in > {1'b0, eff_period});

   genvar k;
   generate
      for (k = 0; k < aroon_pkg::WIN_DEPTH; k++) begin : g_cell
         if (k == 0) begin : g_head
            aroon_cell u_cell (
               .clock      (clock),
               .shift_en   (req_accept),
               .active     (1'b1),
               .cell_age   (aroon_pkg::AGE_W'(k)),
               .sample_in  (req_data),
               .best_in    (best_none),
               .sample_out (sample_q[k]),
               .best_out   (best_q[k])
            );
         end else begin : g_body
            aroon_cell u_cell (
               .clock      (clock),
               .shift_en   (req_accept),
               .active     (aroon_pkg::AGE_W'(k) <= eff_period),
               .cell_age   (aroon_pkg::AGE_W'(k)),
               .sample_in  (sample_q[k-1]),
               .best_in    (best_q[k-1]),
               .sample_out (sample_q[k]),
               .best_out   (best_q[k])
            );
         end
      end
   endgenerate

   // The last cell holds the extremum ages once the scan has run the row.
   assign up_numer = aroon_pkg::NUMER_W'(eff_period - best_q[aroon_pkg::WIN_DEPTH-1].max_age)
                     * aroon_pkg::FULL_SCALE;
   assign down_numer = aroon_pkg::NUMER_W'(eff_period - best_q[aroon_pkg::WIN_DEPTH-1].min_age)
                       * aroon_pkg::FULL_SCALE;

   aroon_div u_div_up (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (up_numer),
      .denom    (eff_period),
      .done     (up_done),
      .quotient (up_quot)
   );

   aroon_div u_div_down (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (down_numer),
      .denom    (eff_period),
      .done     (down_done),
      .quotient (down_quot)
   );

   assign div_start = (state_ff == ST_START);
   assign rsp_load  = (((state_ff == ST_DIV) && up_done) || (state_ff == ST_HOLD))
                      && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && warm_ok) begin
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == aroon_pkg::SCAN_LAST) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (up_done) begin
               state_in = rsp_load ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.aroon_up   = up_quot;
         rsp_data_in.aroon_down = down_quot;
      end
   end

   assign period_in = (csr_valid && csr_ready) ? csr_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         warm_ff      <= '0;
         period_ff    <= aroon_pkg::PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         warm_ff      <= warm_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past((state_ff == ST_DIV) || (state_ff == ST_HOLD)))
      else $error("result word appeared without a finished division");

   a_cold_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !warm_ok) |=> (state_ff == ST_IDLE))
      else $error("warm-up word started a scan");

   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      (up_done == down_done) && (!up_done || (state_ff == ST_DIV)))
      else $error("dividers out of step with the controller");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.aroon_up <= 15'd25600)
                        && (rsp_data_ff.aroon_down <= 15'd25600)))
      else $error("result word above full scale");
`endif

endmodule

`default_nettype wire

### rtl/core/aroon_cell.sv
// One cell of the sample window: holds one high/low sample pair and merges it
// into the running maximum and minimum passed along the row. Uses aroon_pkg.
`default_nettype none

module aroon_cell (
   input  wire                              clock,
   input  wire                              shift_en,
   input  wire                              active,
   input  wire  [aroon_pkg::AGE_W-1:0]      cell_age,
   input  wire  aroon_pkg::req_type         sample_in,
   input  wire  aroon_pkg::best_type        best_in,
   output aroon_pkg::req_type               sample_out,
   output aroon_pkg::best_type              best_out
);

   aroon_pkg::req_type  sample_ff;
   aroon_pkg::req_type  sample_in_w;
   aroon_pkg::best_type best_ff;
   aroon_pkg::best_type best_in_w;

   always_comb begin
      sample_in_w = shift_en ? sample_in : sample_ff;
   end

   // A younger sample already in best_in wins ties, so the own sample needs
   // a strict improvement.
   always_comb begin
      best_in_w = best_in;
      if (active) begin
         best_in_w.seen = 1'b1;
         if (!best_in.seen || (sample_ff.high_sample > best_in.max_key)) begin
            best_in_w.max_key = sample_ff.high_sample;
            best_in_w.max_age = cell_age;
         end
         if (!best_in.seen || (sample_ff.low_sample < best_in.min_key)) begin
            best_in_w.min_key = sample_ff.low_sample;
            best_in_w.min_age = cell_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_w;
      best_ff   <= best_in_w;
   end

   assign sample_out = sample_ff;
   assign best_out   = best_ff;

endmodule

`default_nettype wire

### rtl/core/aroon_div.sv
// Restoring divider, one quotient bit per cycle, for the Aroon scaling step.
// Uses aroon_pkg for widths.
`default_nettype none

module aroon_div (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire  [aroon_pkg::NUMER_W-1:0]      numer,
   input  wire  [aroon_pkg::PERIOD_W-1:0]     denom,
   output logic                               done,
   output logic [aroon_pkg::RESULT_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [aroon_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [aroon_pkg::NUMER_W-1:0]     quot_ff, quot_in;
   logic [aroon_pkg::PERIOD_W-1:0]    rem_ff, rem_in;
   logic [aroon_pkg::PERIOD_W-1:0]    denom_ff, denom_in;
   logic [aroon_pkg::PERIOD_W:0]      trial;
   logic [aroon_pkg::PERIOD_W:0]      diff;

   always_comb begin
      trial = {rem_ff, quot_ff[aroon_pkg::NUMER_W-1]};
      diff  = trial - {1'b0, denom_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         quot_in  = numer;
         rem_in   = '0;
         denom_in = denom;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so the trial never
         // overflows the remainder width once it is kept.
         if (!diff[aroon_pkg::PERIOD_W]) begin
            rem_in  = diff[aroon_pkg::PERIOD_W-1:0];
            quot_in = {quot_ff[aroon_pkg::NUMER_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[aroon_pkg::PERIOD_W-1:0];
            quot_in = {quot_ff[aroon_pkg::NUMER_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == aroon_pkg::STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff[aroon_pkg::RESULT_W-1:0];

endmodule

`default_nettype wire

### dv/aroon_window_extremum_age_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for aroon_window_extremum_age_top: directed and random
// high/low words checked against a local Aroon predictor. Depends on aroon_pkg.

module aroon_window_extremum_age_top_test;
   import aroon_pkg::*;

   localparam int PCT_SCALE       = 25600;
   localparam int DRAIN_CYCLES    = 100;
   localparam int WORDS_PER_PHASE = 50;
   localparam int HOLD_AT_RESULT  = 40;
   localparam int HOLD_CYCLES     = 600;

   localparam logic signed [SAMPLE_W-1:0] P_MAX = 32'sh7FFFFFFF;
   localparam logic signed [SAMPLE_W-1:0] P_MIN = 32'sh80000000;
   localparam logic [RESULT_W-1:0]        A_TOP = 15'd25600;
   localparam logic [RESULT_W-1:0]        A_BOT = 15'd0;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [PERIOD_W-1:0] period;
      req_type             word;
      logic                typed;
      rsp_type             result;
   } stim_row_type;

   localparam int NUM_ROWS = 20;

   // Rows with a typed result use windows of two samples, where the answer
   // is either the full scale or zero.
   localparam stim_row_type STIM_ROWS [NUM_ROWS] = '{
      '{ROW_CSR,  6'd1,  '{32'sd0, 32'sd0},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{P_MAX, P_MIN},     1'b1, '{A_TOP, A_TOP}},
      '{ROW_WORD, 6'd0,  '{P_MIN, P_MAX},     1'b1, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{P_MIN, P_MAX},     1'b1, '{A_TOP, A_TOP}},
      '{ROW_WORD, 6'd0,  '{32'sd0, -32'sd1},  1'b1, '{A_TOP, A_TOP}},
      '{ROW_WORD, 6'd0,  '{-32'sd1, 32'sd0},  1'b1, '{A_BOT, A_BOT}},
      '{ROW_CSR,  6'd0,  '{32'sd0, 32'sd0},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{32'sd0, -32'sd1},  1'b1, '{A_TOP, A_TOP}},
      '{ROW_WORD, 6'd0,  '{32'sd0, -32'sd1},  1'b1, '{A_TOP, A_TOP}},
      '{ROW_CSR,  6'd2,  '{32'sd0, 32'sd0},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{32'sd5, 32'sd5},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{32'sd3, 32'sd7},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{P_MAX, P_MIN},     1'b0, '{A_BOT, A_BOT}},
      '{ROW_CSR,  6'd3,  '{32'sd0, 32'sd0},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{32'sd1, 32'sd9},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{32'sd2, 32'sd6},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{P_MIN, P_MAX},     1'b0, '{A_BOT, A_BOT}},
      '{ROW_CSR,  6'd62, '{32'sd0, 32'sd0},   1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{P_MAX, P_MAX},     1'b0, '{A_BOT, A_BOT}},
      '{ROW_WORD, 6'd0,  '{P_MIN, P_MIN},     1'b0, '{A_BOT, A_BOT}}
   };

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   req_type             req_data  = '0;
   logic                rsp_stall = 1'b0;
   logic                csr_valid = 1'b0;
   logic [PERIOD_W-1:0] csr_data  = '0;
   logic                req_stall;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_ready;

   // Predictor state: sample history, fill level, write slot and period.
   logic signed [SAMPLE_W-1:0] hist_high [WIN_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_low  [WIN_DEPTH];
   int unsigned                held_count = 0;
   int unsigned                wr_slot    = 0;
   logic [PERIOD_W-1:0]        cur_period = PERIOD_RESET;

   rsp_type pending_aroon [$];
   int      mismatches    = 0;
   int      rsp_seen      = 0;
   bit      sender_steady = 1'b0;

   int hold_left  = 0;
   int calm_left  = 0;
   bit hold_fired = 1'b0;

   aroon_window_extremum_age_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // Stores one word and returns 1 with the Aroon pair once period+1 words are held.
   function automatic bit predict_aroon(input req_type w, output rsp_type r);
      int unsigned per, pos, hi_age, lo_age;
      logic signed [SAMPLE_W-1:0] hi_best, lo_best;
      per = (cur_period == 0) ? 1 : cur_period;
      hist_high[wr_slot] = w.high_sample;
      hist_low[wr_slot]  = w.low_sample;
      wr_slot = (wr_slot + 1) % WIN_DEPTH;
      if (held_count < WIN_DEPTH)
         held_count++;
      r = '0;
      if (held_count < per + 1)
         return 1'b0;
      hi_best = '0;
      lo_best = '0;
      hi_age  = 0;
      lo_age  = 0;
      // Strict compares while walking back in age keep the youngest on a tie.
      for (int unsigned age = 0; age <= per; age++) begin
         pos = (wr_slot + WIN_DEPTH - 1 - age) % WIN_DEPTH;
         if (age == 0 || hist_high[pos] > hi_best) begin
            hi_best = hist_high[pos];
            hi_age  = age;
         end
         if (age == 0 || hist_low[pos] < lo_best) begin
            lo_best = hist_low[pos];
            lo_age  = age;
         end
      end
      r.aroon_up   = RESULT_W'(((per - hi_age) * PCT_SCALE) / per);
      r.aroon_down = RESULT_W'(((per - lo_age) * PCT_SCALE) / per);
      return 1'b1;
   endfunction

   function automatic int next_gap();
      int r;
      if (sender_steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(20, 120);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_corner();
      case ($urandom_range(0, 3))
         0:       return P_MAX;
         1:       return P_MIN;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // Offers one word, waits for it to be taken, then records its expectation.
   task automatic send_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      bit      got;
      int      gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_aroon(w, r);
      if (typed)
         pending_aroon.push_back(typed_rsp);
      else if (got)
         pending_aroon.push_back(r);
   endtask

   // The period may change only while the block is idle. A word without a
   // result can still be in flight, so a drain pause follows the last result.
   task automatic write_period(input logic [PERIOD_W-1:0] p);
      req_valid <= 1'b0;
      while (pending_aroon.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= p;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_period = p;
   endtask

   // Receiver: random stalls, calm stretches, and one long hold once results
   // are flowing so that the block backs up onto its input.
   always @(posedge clock) begin
      if (!hold_fired && rsp_seen >= HOLD_AT_RESULT) begin
         hold_fired = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 15))
            0: begin
               calm_left = $urandom_range(50, 300);
               rsp_stall <= 1'b0;
            end
            1: begin
               hold_left = $urandom_range(20, 120);
               rsp_stall <= 1'b1;
            end
            default: rsp_stall <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (pending_aroon.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected word: up=%0d down=%0d",
                        rsp_data.aroon_up, rsp_data.aroon_down);
            mismatches++;
         end else begin
            want = pending_aroon.pop_front();
            if (rsp_data.aroon_up !== want.aroon_up ||
                rsp_data.aroon_down !== want.aroon_down) begin
               if (mismatches < 10)
                  $display("mismatch: expected up=%0d down=%0d, got up=%0d down=%0d",
                           want.aroon_up, want.aroon_down,
                           rsp_data.aroon_up, rsp_data.aroon_down);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_type                    w;
      int                         pick;
      logic signed [SAMPLE_W-1:0] trend_high;
      logic [PERIOD_W-1:0]        phase_periods [8];

      trend_high = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Rising ramp at the reset period: the first result comes on word 26,
      // with the newest high on top and the oldest low at the bottom.
      for (int k = 1; k <= 26; k++) begin
         w.high_sample = k;
         w.low_sample  = k;
         send_word(w, k == 26, '{A_TOP, A_BOT});
      end

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (STIM_ROWS[i].kind == ROW_CSR)
            write_period(STIM_ROWS[i].period);
         else
            send_word(STIM_ROWS[i].word, STIM_ROWS[i].typed, STIM_ROWS[i].result);
      end

      phase_periods = '{6'd63, 6'($urandom_range(4, 40)), 6'd1, 6'd0, 6'd63,
                        6'($urandom_range(1, 62)), 6'd2, 6'd25};
      for (int ph = 0; ph < 8; ph++) begin
         write_period(phase_periods[ph]);
         sender_steady = (ph == 2 || ph == 5);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               w.high_sample = $urandom;
               w.low_sample  = $urandom;
            end else if (pick < 6) begin
               // Narrow range so that ties are common.
               w.high_sample = $urandom_range(0, 6) - 3;
               w.low_sample  = $urandom_range(0, 6) - 3;
            end else if (pick == 6) begin
               w.high_sample = pick_corner();
               w.low_sample  = pick_corner();
            end else begin
               trend_high    = trend_high + $urandom_range(0, 8) - 3;
               w.high_sample = trend_high;
               w.low_sample  = trend_high - $urandom_range(0, 10);
            end
            send_word(w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_aroon.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
rtl/core/aroon_pkg.sv
rtl/core/aroon_cell.sv
rtl/core/aroon_div.sv
rtl/core/aroon_window_extremum_age_top.sv
dv/aroon_window_extremum_age_top_test.sv
